[design/sgas_pkg.sv]
// ----------------------------------------------------------------------------
// sgas_pkg
// Shared types and constants for the sensor grid averaging and smoothing core
// ----------------------------------------------------------------------------
package sgas_pkg;

  localparam int SCAN_ROWS  = 16;
  localparam int SCAN_COLS  = 15;
  localparam int CELL_COUNT = SCAN_ROWS * SCAN_COLS;
  localparam int CELL_W     = $clog2(CELL_COUNT);

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int FS_W     = 12;
  localparam int OM_W     = 10;
  localparam int WEIGHT_W = 8;
  localparam int LEVEL_W  = 10;
  localparam int STORE_W  = 18;

  // shared divider: quotient/dividend register and step counts
  localparam int DIV_W       = SUM_W + OM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int AVG_STEPS   = SUM_W;
  localparam int SCALE_STEPS = DIV_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_CELL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAX       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 3'd4;

  localparam logic [COUNT_W-1:0]  RST_SAMPLES_PER_CELL = 5'd5;
  localparam logic [FS_W-1:0]     RST_FULL_SCALE       = 12'd3300;
  localparam logic [OM_W-1:0]     RST_OUTPUT_MAX       = 10'd1000;
  localparam logic                RST_SMOOTHING_ON     = 1'b1;
  localparam logic [WEIGHT_W-1:0] RST_SMOOTHING_WEIGHT = 8'd179;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 5'd16;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DIV_AVG,
    ST_MUL_SCALE,
    ST_DIV_SCALE,
    ST_SAT,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM,
    ST_EMIT
  } sgas_state_t;

  typedef struct packed {
    logic accum;
    logic load_avg;
    logic load_scale;
    logic div_step;
    logic sat;
    logic mul_old;
    logic mul_new;
    logic sum;
    logic emit;
  } sgas_cmd_t;

  typedef struct packed {
    logic finish_hit;
    logic div_last;
    logic out_free;
  } sgas_stat_t;

endpackage

[design/sensor_grid_average_smooth_core.sv]
// ----------------------------------------------------------------------------
// sensor_grid_average_smooth_core
// Oversampled ADC cell averaging, full-scale normalisation and per-cell
// exponential smoothing for a row-by-row scanned sensor grid
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_adc_sample
//   out_     output     out_valid/out_stall out_cell_row, out_cell_col,
//                                           out_level, out_frame_end
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// a sample that does not finish a cell is taken without a stall; after a
// cell-finishing sample the input stalls while the shared bit-serial divider
// runs (16 steps for the average, 26 for scaling) and through the smoothing
// steps; synchronous active-low reset; the cell store is written for every
// cell, and smoothing (when on) starts on the second scan; samples are still
// taken while a result waits on out_stall; a finished cell waits for the output register to free
// ----------------------------------------------------------------------------
module sensor_grid_average_smooth_core import sgas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_cell_row,
  output logic [COL_W-1:0]      out_cell_col,
  output logic [LEVEL_W-1:0]    out_level,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sgas_cmd_t  cmd;
  sgas_stat_t stat;

  assign cfg_ready = 1'b1;

  sgas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sgas_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_row  (out_cell_row),
    .out_cell_col  (out_cell_col),
    .out_level     (out_level),
    .out_frame_end (out_frame_end)
  );

endmodule

[design/sgas_ctrl.sv]
// ----------------------------------------------------------------------------
// sgas_ctrl
// Sequencer: accumulation, two divider passes, smoothing steps and emit
// ----------------------------------------------------------------------------
module sgas_ctrl import sgas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sgas_stat_t  stat,
  output sgas_cmd_t   cmd
);

  sgas_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACCUM: begin
        if (in_valid && stat.finish_hit) begin
          state_nxt = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (stat.div_last) begin
          state_nxt = ST_MUL_SCALE;
        end
      end
      ST_MUL_SCALE: state_nxt = ST_DIV_SCALE;
      ST_DIV_SCALE: begin
        if (stat.div_last) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT:     state_nxt = ST_MUL_OLD;
      ST_MUL_OLD: state_nxt = ST_MUL_NEW;
      ST_MUL_NEW: state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = ST_ACCUM;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_ACCUM: begin
        in_stall     = 1'b0;
        cmd.accum    = in_valid;
        cmd.load_avg = in_valid && stat.finish_hit;
      end
      ST_DIV_AVG:   cmd.div_step   = 1'b1;
      ST_MUL_SCALE: cmd.load_scale = 1'b1;
      ST_DIV_SCALE: cmd.div_step   = 1'b1;
      ST_SAT:       cmd.sat        = 1'b1;
      ST_MUL_OLD:   cmd.mul_old    = 1'b1;
      ST_MUL_NEW:   cmd.mul_new    = 1'b1;
      ST_SUM:       cmd.sum        = 1'b1;
      ST_EMIT:      cmd.emit       = stat.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[design/sgas_dp.sv]
// ----------------------------------------------------------------------------
// sgas_dp
// Datapath: config registers, sample accumulator, bit-serial divider,
// smoothing multipliers, per-cell store and output register
// ----------------------------------------------------------------------------
module sgas_dp import sgas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sgas_cmd_t             cmd,
  output sgas_stat_t            stat,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SAMPLE_W-1:0]   in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_cell_row,
  output logic [COL_W-1:0]      out_cell_col,
  output logic [LEVEL_W-1:0]    out_level,
  output logic                  out_frame_end
);

  // config
  logic [COUNT_W-1:0]  spc_r;
  logic [FS_W-1:0]     fs_r;
  logic [OM_W-1:0]     om_r;
  logic                smooth_on_r;
  logic [WEIGHT_W-1:0] weight_r;

  // scan state
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [CELL_W-1:0]  cell_r;
  logic               first_done_r;
  logic               out_valid_r;

  // divider
  logic [DIV_W-1:0]     div_q_r, div_q_nxt;
  logic [FS_W-1:0]      div_rem_r, div_rem_nxt;
  logic [FS_W-1:0]      div_d_r, div_d_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [FS_W:0]        rem_sh, rem_sub;
  logic                 rem_ge;

  // smoothing
  logic [OM_W-1:0]    m_r;
  logic [STORE_W-1:0] old_r;
  logic [25:0]        p_old_r;
  logic [26:0]        p_new_r;
  logic [STORE_W-1:0] stored_r;
  logic [27:0]        blend;
  logic [8:0]         new_weight;

  logic [STORE_W-1:0] store_mem [CELL_COUNT];

  // output payload
  logic [ROW_W-1:0]   row_out_r;
  logic [COL_W-1:0]   col_out_r;
  logic [LEVEL_W-1:0] level_out_r;
  logic               frame_end_r;

  logic [COUNT_W-1:0] n_eff;
  logic [FS_W-1:0]    fs_eff;
  logic               last_cell;
  logic               out_take;
  logic [STORE_W:0]   lv_round;
  logic [LEVEL_W:0]   lv_wide;
  logic [LEVEL_W-1:0] lv_sat;

  assign n_eff = (spc_r == '0) ? COUNT_W'(1) :
                 (spc_r > MAX_SAMPLES) ? MAX_SAMPLES : spc_r;
  assign fs_eff = (fs_r == '0) ? FS_W'(1) : fs_r;

  assign last_cell = (row_r == ROW_W'(SCAN_ROWS - 1)) && (col_r == COL_W'(SCAN_COLS - 1));
  assign out_take  = out_valid_r && !out_stall;

  assign stat.finish_hit = (count_r != '0) && (count_r >= n_eff);
  assign stat.div_last   = (div_cnt_r == DIV_CNT_W'(1));
  assign stat.out_free   = !out_valid_r || !out_stall;

  // accumulation
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (cmd.accum) begin
      if (count_r == '0) begin
        count_nxt = COUNT_W'(1);
      end else if (stat.finish_hit) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_r + SUM_W'(in_adc_sample);
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {div_rem_r, div_q_r[DIV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_d_r};
  assign rem_sub = rem_sh - {1'b0, div_d_r};

  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.load_avg) begin
      div_q_nxt   = {sum_r + SUM_W'(in_adc_sample), OM_W'(0)};
      div_rem_nxt = '0;
      div_d_nxt   = FS_W'(n_eff);
      div_cnt_nxt = DIV_CNT_W'(AVG_STEPS);
    end else if (cmd.load_scale) begin
      div_q_nxt   = DIV_W'(div_q_r[SUM_W-1:0]) * DIV_W'(om_r);
      div_rem_nxt = '0;
      div_d_nxt   = fs_eff;
      div_cnt_nxt = DIV_CNT_W'(SCALE_STEPS);
    end else if (cmd.div_step) begin
      div_q_nxt   = {div_q_r[DIV_W-2:0], rem_ge};
      div_rem_nxt = rem_ge ? rem_sub[FS_W-1:0] : rem_sh[FS_W-1:0];
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end
  end

  assign new_weight = 9'd256 - 9'(weight_r);
  assign blend      = 28'(p_old_r) + 28'(p_new_r) + 28'd128;

  assign lv_round = (STORE_W + 1)'(stored_r) + (STORE_W + 1)'(128);
  assign lv_wide  = lv_round[STORE_W:8];
  assign lv_sat   = (lv_wide > (LEVEL_W + 1)'(1023)) ? LEVEL_W'(1023) : lv_wide[LEVEL_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r        <= RST_SAMPLES_PER_CELL;
      fs_r         <= RST_FULL_SCALE;
      om_r         <= RST_OUTPUT_MAX;
      smooth_on_r  <= RST_SMOOTHING_ON;
      weight_r     <= RST_SMOOTHING_WEIGHT;
      sum_r        <= '0;
      count_r      <= '0;
      row_r        <= '0;
      col_r        <= '0;
      cell_r       <= '0;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SAMPLES_PER_CELL: spc_r       <= cfg_wdata[COUNT_W-1:0];
          CFG_FULL_SCALE:       fs_r        <= cfg_wdata[FS_W-1:0];
          CFG_OUTPUT_MAX:       om_r        <= cfg_wdata[OM_W-1:0];
          CFG_SMOOTHING_ON:     smooth_on_r <= cfg_wdata[0];
          CFG_SMOOTHING_WEIGHT: weight_r    <= cfg_wdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      div_cnt_r <= div_cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_cell) begin
          row_r        <= '0;
          col_r        <= '0;
          cell_r       <= '0;
          first_done_r <= 1'b1;
        end else if (col_r == COL_W'(SCAN_COLS - 1)) begin
          col_r  <= '0;
          row_r  <= row_r + ROW_W'(1);
          cell_r <= cell_r + CELL_W'(1);
        end else begin
          col_r  <= col_r + COL_W'(1);
          cell_r <= cell_r + CELL_W'(1);
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
    if (cmd.sat) begin
      m_r <= (div_q_r > DIV_W'(om_r)) ? om_r : div_q_r[OM_W-1:0];
    end
    if (cmd.mul_old) begin
      p_old_r <= 26'(weight_r) * 26'(old_r);
    end
    if (cmd.mul_new) begin
      p_new_r <= 27'(new_weight) * 27'({m_r, 8'b0});
    end
    if (cmd.sum) begin
      stored_r <= (smooth_on_r && first_done_r) ? blend[25:8] : {m_r, 8'b0};
    end
    if (cmd.emit) begin
      row_out_r   <= row_r;
      col_out_r   <= col_r;
      level_out_r <= lv_sat;
      frame_end_r <= last_cell;
    end
  end

  // per-cell smoothing store
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      store_mem[cell_r] <= stored_r;
    end
    old_r <= store_mem[cell_r];
  end

  assign out_valid     = out_valid_r;
  assign out_cell_row  = row_out_r;
  assign out_cell_col  = col_out_r;
  assign out_level     = level_out_r;
  assign out_frame_end = frame_end_r;

endmodule
